FILE: design/lrc_pkg.sv
// Shared types and constants for the clipped line rasterizer.
// No dependencies; imported by every module of the block.
package lrc_pkg;

    // Coordinate width after subtracting two 16-bit endpoints
    localparam int COORD_W = 17;
    // Error term width, holds twice a 17-bit delta with sign
    localparam int ERR_W = 20;
    // Held pixel coordinate width, on-screen values only
    localparam int HELD_W = 16;
    // Output field widths
    localparam int PIX_W = 6;
    localparam int ADDR_W = 14;
    localparam int COLOR_W = 8;
    // Bytes per pixel in the frame buffer
    localparam int BYTES_PER_PIXEL = 3;

    // Result cap per line command
    localparam int MAX_RESULTS = 64;
    localparam int COUNT_W = 7;

    // Setup queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    // One classified line, ready for the walker
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] major_end;
        logic signed [ERR_W-1:0]   error_init;
        logic signed [ERR_W-1:0]   inc_straight;
        logic signed [ERR_W-1:0]   inc_diag;
        logic                      x_is_major;
        logic                      minor_dir_up;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
    } line_setup_t;

    // Walker states
    typedef enum logic [1:0] {
        W_IDLE,
        W_WALK,
        W_FLUSH
    } walk_state_t;

endpackage

FILE: design/line_rasterizer_clipped.sv
// Top level of the clipped Bresenham line rasterizer.
// Depends on lrc_pkg, lrc_front, lrc_queue and lrc_walker.
//
// A line request is taken on a clock edge with start high and busy low. The
// front end registers and classifies it and parks it in a two-entry queue, so
// up to three requests can be in hand while the walker draws. The walker
// steps along the full line, on-screen or not, between a load and a flush
// state. Each pixel write is shown for one cycle with pixel_write high and
// cannot be stalled; the last write of a line carries last_pixel, and a
// fully clipped line gives no write at all. At most 64 writes are made per
// line; the 64th is then marked last.
module line_rasterizer_clipped
    import lrc_pkg::*;
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic [7:0]         color_red,
    input  logic [7:0]         color_green,
    input  logic [7:0]         color_blue,
    output logic               pixel_write,
    output logic [5:0]         pixel_x,
    output logic [5:0]         pixel_y,
    output logic [13:0]        pixel_address,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               last_pixel
);

    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;
    line_setup_t q_push_data;
    line_setup_t q_head;

    // Accept and classify requests
    lrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .q_full      (q_full),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    // Hold classified lines between front and back
    lrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Walk, clip and emit
    lrc_walker #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .pixel_write   (pixel_write),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .last_pixel    (last_pixel)
    );

endmodule

FILE: design/lrc_front.sv
// Command front end: registers a line request, classifies it and pushes setup.
// Depends on lrc_pkg.
module lrc_front
    import lrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic [7:0]         color_red,
    input  logic [7:0]         color_green,
    input  logic [7:0]         color_blue,
    input  logic               q_full,
    output logic               push,
    output line_setup_t        push_data
);

    logic                      cmd_valid_reg;
    logic                      cmd_valid_next;
    logic signed [15:0]        x1_reg;
    logic signed [15:0]        y1_reg;
    logic signed [15:0]        x2_reg;
    logic signed [15:0]        y2_reg;
    logic [COLOR_W-1:0]        red_reg;
    logic [COLOR_W-1:0]        green_reg;
    logic [COLOR_W-1:0]        blue_reg;

    logic                      accept;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [COORD_W-1:0]        adx;
    logic [COORD_W-1:0]        ady;
    logic [COORD_W-1:0]        major_len;
    logic [COORD_W-1:0]        minor_len;
    logic signed [ERR_W-1:0]   twice_major;
    logic signed [ERR_W-1:0]   twice_minor;
    logic                      x_major;
    logic                      from_first;

    // Accept a request while the held command can move on
    assign busy   = cmd_valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = cmd_valid_reg && !q_full;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (push)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg    <= start_x;
            y1_reg    <= start_y;
            x2_reg    <= end_x;
            y2_reg    <= end_y;
            red_reg   <= color_red;
            green_reg <= color_green;
            blue_reg  <= color_blue;
        end
    end

    // Classify: deltas, magnitudes, major axis
    assign dx  = COORD_W'(x2_reg) - COORD_W'(x1_reg);
    assign dy  = COORD_W'(y2_reg) - COORD_W'(y1_reg);
    assign adx = dx[COORD_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    assign ady = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);

    // Axis-aligned lines fall out of the same rule with a zero minor delta
    assign x_major   = (ady <= adx);
    assign major_len = x_major ? adx : ady;
    assign minor_len = x_major ? ady : adx;
    assign twice_major = $signed({2'b00, major_len, 1'b0});
    assign twice_minor = $signed({2'b00, minor_len, 1'b0});

    // Walk from the endpoint with the smaller major coordinate
    assign from_first = x_major ? !dx[COORD_W-1] : !dy[COORD_W-1];

    always_comb
    begin
        push_data.start_x      = from_first ? COORD_W'(x1_reg) : COORD_W'(x2_reg);
        push_data.start_y      = from_first ? COORD_W'(y1_reg) : COORD_W'(y2_reg);
        if (x_major)
        begin
            push_data.major_end = from_first ? COORD_W'(x2_reg) : COORD_W'(x1_reg);
        end
        else
        begin
            push_data.major_end = from_first ? COORD_W'(y2_reg) : COORD_W'(y1_reg);
        end
        push_data.error_init   = twice_minor - $signed({3'b000, major_len});
        push_data.inc_straight = twice_minor;
        push_data.inc_diag     = twice_minor - twice_major;
        push_data.x_is_major   = x_major;
        push_data.minor_dir_up = ((dx > 0) == (dy > 0));
        push_data.red          = red_reg;
        push_data.green        = green_reg;
        push_data.blue         = blue_reg;
    end

endmodule

FILE: design/lrc_queue.sv
// Two-entry setup queue between the front end and the walker.
// Depends on lrc_pkg for the entry type and depth.
module lrc_queue
    import lrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  line_setup_t push_data,
    input  logic        pop,
    output line_setup_t head,
    output logic        empty,
    output logic        full
);

    line_setup_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/lrc_walker.sv
// Back end: walks one classified line per pass, clips, and emits pixel writes.
// Depends on lrc_pkg; fed by lrc_queue.
module lrc_walker
    import lrc_pkg::*;
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  line_setup_t        q_head,
    input  logic               q_empty,
    output logic               pop,
    output logic               pixel_write,
    output logic [PIX_W-1:0]   pixel_x,
    output logic [PIX_W-1:0]   pixel_y,
    output logic [ADDR_W-1:0]  pixel_address,
    output logic [COLOR_W-1:0] red_out,
    output logic [COLOR_W-1:0] green_out,
    output logic [COLOR_W-1:0] blue_out,
    output logic               last_pixel
);

    localparam logic signed [COORD_W-1:0] X_LIMIT = COORD_W'(FRAME_WIDTH);
    localparam logic signed [COORD_W-1:0] Y_LIMIT = COORD_W'(FRAME_HEIGHT);
    localparam logic [ADDR_W-1:0]  ROW_BYTES = ADDR_W'(FRAME_WIDTH);
    localparam logic [ADDR_W-1:0]  PIX_BYTES = ADDR_W'(BYTES_PER_PIXEL);
    localparam logic [COUNT_W-1:0] CAP       = COUNT_W'(MAX_RESULTS);
    localparam logic [COUNT_W-1:0] LAST_SLOT = COUNT_W'(MAX_RESULTS - 1);

    walk_state_t               state_reg;
    walk_state_t               state_next;

    logic signed [COORD_W-1:0] cur_x_reg;
    logic signed [COORD_W-1:0] cur_y_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [COORD_W-1:0] end_reg;
    logic signed [ERR_W-1:0]   inc_straight_reg;
    logic signed [ERR_W-1:0]   inc_diag_reg;
    logic                      x_major_reg;
    logic                      dir_up_reg;
    logic [COLOR_W-1:0]        red_reg;
    logic [COLOR_W-1:0]        green_reg;
    logic [COLOR_W-1:0]        blue_reg;

    logic                      held_valid_reg;
    logic [HELD_W-1:0]         held_x_reg;
    logic [HELD_W-1:0]         held_y_reg;
    logic [COUNT_W-1:0]        count_reg;

    logic                      pixel_write_reg;
    logic [PIX_W-1:0]          pixel_x_reg;
    logic [PIX_W-1:0]          pixel_y_reg;
    logic [ADDR_W-1:0]         pixel_address_reg;
    logic [COLOR_W-1:0]        red_out_reg;
    logic [COLOR_W-1:0]        green_out_reg;
    logic [COLOR_W-1:0]        blue_out_reg;
    logic                      last_pixel_reg;

    logic                      visible;
    logic                      at_end;
    logic                      take_minor;
    logic                      room;
    logic                      emit;
    logic                      emit_last;
    logic signed [COORD_W-1:0] cur_major;
    logic signed [COORD_W-1:0] minor_step;
    logic signed [COORD_W-1:0] cur_x_next;
    logic signed [COORD_W-1:0] cur_y_next;
    logic signed [ERR_W-1:0]   err_next;
    logic [ADDR_W-1:0]         held_address;

    // Clip test on the current walk position
    assign visible = (cur_x_reg >= 0) && (cur_x_reg < X_LIMIT)
                  && (cur_y_reg >= 0) && (cur_y_reg < Y_LIMIT);

    assign cur_major = x_major_reg ? cur_x_reg : cur_y_reg;
    assign at_end    = (cur_major >= end_reg);
    assign room      = (count_reg < CAP);

    // Bresenham step: x-major steps minor on err >= 0, y-major on err > 0
    assign take_minor = x_major_reg ? !err_reg[ERR_W-1]
                                    : (!err_reg[ERR_W-1] && (err_reg != '0));
    assign minor_step = dir_up_reg ? COORD_W'(1) : COORD_W'(-1);
    assign err_next   = take_minor ? (err_reg + inc_diag_reg)
                                   : (err_reg + inc_straight_reg);

    always_comb
    begin
        if (x_major_reg)
        begin
            cur_x_next = cur_x_reg + COORD_W'(1);
            cur_y_next = take_minor ? (cur_y_reg + minor_step) : cur_y_reg;
        end
        else
        begin
            cur_y_next = cur_y_reg + COORD_W'(1);
            cur_x_next = take_minor ? (cur_x_reg + minor_step) : cur_x_reg;
        end
    end

    // Byte address of the held pixel's red byte, wrapped to the port width
    assign held_address = (held_y_reg[ADDR_W-1:0] * ROW_BYTES + held_x_reg[ADDR_W-1:0])
                        * PIX_BYTES;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = W_WALK;
                end
            end
            W_WALK:
            begin
                if (at_end)
                begin
                    state_next = W_FLUSH;
                end
            end
            W_FLUSH:
            begin
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // State outputs: pop a setup, emit or flush the held pixel
    always_comb
    begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        unique case (state_reg)
            W_IDLE:
            begin
                pop = !q_empty;
            end
            W_WALK:
            begin
                emit      = visible && held_valid_reg && room;
                emit_last = (count_reg == LAST_SLOT);
            end
            W_FLUSH:
            begin
                emit      = held_valid_reg && room;
                emit_last = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= W_IDLE;
            held_valid_reg  <= 1'b0;
            count_reg       <= '0;
            pixel_write_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_write_reg <= emit;
            if (pop)
            begin
                held_valid_reg <= 1'b0;
                count_reg      <= '0;
            end
            else
            begin
                if (emit)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (state_reg == W_WALK && visible)
                begin
                    held_valid_reg <= 1'b1;
                end
                else if (state_reg == W_FLUSH)
                begin
                    held_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Walk datapath: load on pop, step until the major end
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_x_reg        <= q_head.start_x;
            cur_y_reg        <= q_head.start_y;
            err_reg          <= q_head.error_init;
            end_reg          <= q_head.major_end;
            inc_straight_reg <= q_head.inc_straight;
            inc_diag_reg     <= q_head.inc_diag;
            x_major_reg      <= q_head.x_is_major;
            dir_up_reg       <= q_head.minor_dir_up;
            red_reg          <= q_head.red;
            green_reg        <= q_head.green;
            blue_reg         <= q_head.blue;
        end
        else if (state_reg == W_WALK)
        begin
            if (visible)
            begin
                held_x_reg <= cur_x_reg[HELD_W-1:0];
                held_y_reg <= cur_y_reg[HELD_W-1:0];
            end
            if (!at_end)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                err_reg   <= err_next;
            end
        end
    end

    // Output register: drive the previously held pixel
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg       <= held_x_reg[PIX_W-1:0];
            pixel_y_reg       <= held_y_reg[PIX_W-1:0];
            pixel_address_reg <= held_address;
            red_out_reg       <= red_reg;
            green_out_reg     <= green_reg;
            blue_out_reg      <= blue_reg;
            last_pixel_reg    <= emit_last;
        end
    end

    assign pixel_write   = pixel_write_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_address = pixel_address_reg;
    assign red_out       = red_out_reg;
    assign green_out     = green_out_reg;
    assign blue_out      = blue_out_reg;
    assign last_pixel    = last_pixel_reg;

    // A write follows a walk or flush cycle only
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_write_reg |-> ($past(state_reg) == W_WALK || $past(state_reg) == W_FLUSH))
        else $error("pixel write without a walk or flush cycle");

    // Nothing follows the last write of a line in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_write_reg && last_pixel_reg) |=> !pixel_write_reg)
        else $error("pixel write right after the last pixel");

    // Result count stays within the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("result count above cap");

    // The flush cycle empties the held pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_FLUSH) |=> !held_valid_reg)
        else $error("held pixel survives flush");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for line_rasterizer_clipped: drives line requests and checks every pixel write
// against a built-in Bresenham predictor with clipping. Depends on lrc_pkg and the block.
module testbench;
    import lrc_pkg::*;

    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 64;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_PER_PHASE = 62;
    // Three short lines still in hand after the last expected write
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int MAX_PRINTED = 40;

    typedef logic signed [15:0] coord_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } line_cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } pixel_write_t;

    // How a directed row gets its expectation
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_NONE,
        CHECK_ONE
    } check_kind_t;

    typedef struct packed {
        check_kind_t  kind;
        line_cmd_t    cmd;
        pixel_write_t typed;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    coord_t             start_x;
    coord_t             start_y;
    coord_t             end_x;
    coord_t             end_y;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
    logic               pixel_write;
    logic [5:0]         pixel_x;
    logic [5:0]         pixel_y;
    logic [13:0]        pixel_address;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               last_pixel;

    pixel_write_t  pending_pixels[$];
    directed_row_t directed_rows[$];

    // Predictor scratch for the line being traced
    line_cmd_t     tracing_cmd;
    pixel_write_t  line_pixels[$];
    bit            held_valid;
    int            held_x;
    int            held_y;

    int send_idle_pct;
    int mismatch_count;
    int pixels_checked;
    int lines_sent;
    int cycle_count;

    line_rasterizer_clipped #(
        .FRAME_WIDTH  (SCREEN_W),
        .FRAME_HEIGHT (SCREEN_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .color_red     (color_red),
        .color_green   (color_green),
        .color_blue    (color_blue),
        .pixel_write   (pixel_write),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .last_pixel    (last_pixel)
    );

    // Free-running clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Append one write for the current line, up to the per-line cap
    function automatic void emit_pixel(input int x, input int y, input bit last);
        pixel_write_t p;
        int a;
        if (line_pixels.size() >= MAX_RESULTS)
            return;
        a = (y * SCREEN_W + x) * BYTES_PER_PIXEL;
        p.x = x[PIX_W-1:0];
        p.y = y[PIX_W-1:0];
        p.address = a[ADDR_W-1:0];
        p.red = tracing_cmd.red;
        p.green = tracing_cmd.green;
        p.blue = tracing_cmd.blue;
        p.last = last;
        line_pixels.push_back(p);
    endfunction

    // Drop off-screen pixels; flush the held one and hold this one
    function automatic void offer_pixel(input int x, input int y);
        if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H)
            return;
        if (held_valid)
            emit_pixel(held_x, held_y, 1'b0);
        held_valid = 1'b1;
        held_x = x;
        held_y = y;
    endfunction

    // Walk the Bresenham line of one request and queue its expected writes
    function automatic void trace_line(input line_cmd_t c);
        int x1, y1, x2, y2;
        int dx, dy, adx, ady;
        int cx, cy, major_stop, minor_step;
        longint err;
        pixel_write_t p;
        x1 = c.x1;
        y1 = c.y1;
        x2 = c.x2;
        y2 = c.y2;
        dx = x2 - x1;
        dy = y2 - y1;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        tracing_cmd = c;
        line_pixels.delete();
        held_valid = 1'b0;

        if (dx == 0) begin
            // vertical, also a single point: smaller y first
            for (cy = (y1 < y2 ? y1 : y2); cy <= (y1 < y2 ? y2 : y1); cy++)
                offer_pixel(x1, cy);
        end
        else if (dy == 0) begin
            // horizontal: smaller x first
            for (cx = (x1 < x2 ? x1 : x2); cx <= (x1 < x2 ? x2 : x1); cx++)
                offer_pixel(cx, y1);
        end
        else begin
            minor_step = ((dx > 0) == (dy > 0)) ? 1 : -1;
            if (ady <= adx) begin
                // x-major: step y when the error is not negative
                err = 2 * ady - adx;
                if (dx >= 0) begin
                    cx = x1; cy = y1; major_stop = x2;
                end
                else begin
                    cx = x2; cy = y2; major_stop = x1;
                end
                offer_pixel(cx, cy);
                while (cx < major_stop) begin
                    cx++;
                    if (err < 0)
                        err += 2 * ady;
                    else begin
                        cy += minor_step;
                        err += 2 * (ady - adx);
                    end
                    offer_pixel(cx, cy);
                end
            end
            else begin
                // y-major: step x only when the error is positive
                err = 2 * adx - ady;
                if (dy >= 0) begin
                    cx = x1; cy = y1; major_stop = y2;
                end
                else begin
                    cx = x2; cy = y2; major_stop = y1;
                end
                offer_pixel(cx, cy);
                while (cy < major_stop) begin
                    cy++;
                    if (err <= 0)
                        err += 2 * adx;
                    else begin
                        cx += minor_step;
                        err += 2 * (adx - ady);
                    end
                    offer_pixel(cx, cy);
                end
            end
        end

        // Mark the final write; at the cap the last kept one takes the mark
        if (held_valid) begin
            if (line_pixels.size() >= MAX_RESULTS) begin
                p = line_pixels.pop_back();
                p.last = 1'b1;
                line_pixels.push_back(p);
            end
            else
                emit_pixel(held_x, held_y, 1'b1);
        end
        foreach (line_pixels[i])
            pending_pixels.push_back(line_pixels[i]);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic coord_t pick_coord(input int span, input int offset);
        int v;
        v = $urandom_range(span);
        v = v + offset;
        return v[15:0];
    endfunction

    function automatic logic [7:0] pick_byte();
        int v;
        v = $urandom;
        return v[7:0];
    endfunction

    task automatic add_row(input check_kind_t kind, input int x1, input int y1,
                           input int x2, input int y2, input int r, input int g,
                           input int b, input int px, input int py, input int addr);
        directed_row_t row;
        row.kind = kind;
        row.cmd.x1 = x1[15:0];
        row.cmd.y1 = y1[15:0];
        row.cmd.x2 = x2[15:0];
        row.cmd.y2 = y2[15:0];
        row.cmd.red = r[7:0];
        row.cmd.green = g[7:0];
        row.cmd.blue = b[7:0];
        row.typed.x = px[PIX_W-1:0];
        row.typed.y = py[PIX_W-1:0];
        row.typed.address = addr[ADDR_W-1:0];
        row.typed.red = r[7:0];
        row.typed.green = g[7:0];
        row.typed.blue = b[7:0];
        row.typed.last = 1'b1;
        directed_rows.push_back(row);
    endtask

    // Issue one request; entered and left at a falling edge
    task automatic send_line(input line_cmd_t c, input bit use_model);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start_x <= c.x1;
        start_y <= c.y1;
        end_x <= c.x2;
        end_y <= c.y2;
        color_red <= c.red;
        color_green <= c.green;
        color_blue <= c.blue;
        start <= 1'b1;
        // hold until taken: start high and busy low at a rising edge
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        lines_sent++;
        if (use_model)
            trace_line(c);
    endtask

    // Random line: mostly near the screen, some wider, a few across the full range
    function automatic line_cmd_t random_line(input bit allow_wide);
        line_cmd_t c;
        int sel;
        int shape;
        int span;
        int offset;
        sel = $urandom_range(99);
        if (allow_wide && sel < 2) begin
            span = 65535; offset = -32768;
        end
        else if (allow_wide && sel < 10) begin
            span = 600; offset = -300;
        end
        else begin
            span = 103; offset = -20;
        end
        c.x1 = pick_coord(span, offset);
        c.y1 = pick_coord(span, offset);
        c.x2 = pick_coord(span, offset);
        c.y2 = pick_coord(span, offset);
        shape = $urandom_range(9);
        if (shape == 0)
            c.x2 = c.x1;
        else if (shape == 1)
            c.y2 = c.y1;
        else if (shape == 2) begin
            c.x2 = c.x1;
            c.y2 = c.y1;
        end
        c.red = pick_byte();
        c.green = pick_byte();
        c.blue = pick_byte();
        return c;
    endfunction

    task automatic run_random(input int idle_pct, input int count);
        send_idle_pct = idle_pct;
        // keep the closing lines short so the drain wait covers them
        for (int i = 0; i < count; i++)
            send_line(random_line(i < count - 3), 1'b1);
    endtask

    // Check each pixel write against the oldest expectation
    always @(posedge clk) begin : check_writes
        pixel_write_t want;
        if (rst_n && pixel_write) begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("unexpected write x=%0d y=%0d addr=%0d",
                                          pixel_x, pixel_y, pixel_address));
            else begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.x)
                    report_mismatch($sformatf("write %0d pixel_x %0d, expected %0d",
                                              pixels_checked, pixel_x, want.x));
                if (pixel_y !== want.y)
                    report_mismatch($sformatf("write %0d pixel_y %0d, expected %0d",
                                              pixels_checked, pixel_y, want.y));
                if (pixel_address !== want.address)
                    report_mismatch($sformatf("write %0d pixel_address %0d, expected %0d",
                                              pixels_checked, pixel_address, want.address));
                if (red_out !== want.red)
                    report_mismatch($sformatf("write %0d red_out %0h, expected %0h",
                                              pixels_checked, red_out, want.red));
                if (green_out !== want.green)
                    report_mismatch($sformatf("write %0d green_out %0h, expected %0h",
                                              pixels_checked, green_out, want.green));
                if (blue_out !== want.blue)
                    report_mismatch($sformatf("write %0d blue_out %0h, expected %0h",
                                              pixels_checked, blue_out, want.blue));
                if (last_pixel !== want.last)
                    report_mismatch($sformatf("write %0d last_pixel %0b, expected %0b",
                                              pixels_checked, last_pixel, want.last));
            end
            pixels_checked++;
        end
    end

    // Abort a run that hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixel writes still expected",
                     cycle_count, pending_pixels.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        color_red = '0;
        color_green = '0;
        color_blue = '0;
        mismatch_count = 0;
        pixels_checked = 0;
        lines_sent = 0;
        cycle_count = 0;
        send_idle_pct = 0;

        // Single points at the corners and inside, with hand-typed writes
        add_row(CHECK_ONE, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 0, 0);
        add_row(CHECK_ONE, 63, 63, 63, 63, 8'hff, 8'hff, 8'hff, 63, 63, 12285);
        add_row(CHECK_ONE, 63, 0, 63, 0, 8'h55, 8'haa, 8'h0f, 63, 0, 189);
        add_row(CHECK_ONE, 0, 63, 0, 63, 8'h80, 8'h01, 8'hfe, 0, 63, 12096);
        add_row(CHECK_ONE, 31, 17, 31, 17, 8'h12, 8'h34, 8'h56, 31, 17, 3357);
        // Fully clipped lines: no write at all
        add_row(CHECK_NONE, 64, 0, 64, 0, 8'h11, 8'h22, 8'h33, 0, 0, 0);
        add_row(CHECK_NONE, -1, -1, -1, -1, 8'h44, 8'h55, 8'h66, 0, 0, 0);
        add_row(CHECK_NONE, -10, -5, -1, -20, 8'h77, 8'h88, 8'h99, 0, 0, 0);
        add_row(CHECK_NONE, 64, 0, 100, 63, 8'haa, 8'hbb, 8'hcc, 0, 0, 0);
        // Reversed vertical and horizontal, clip at coordinate zero
        add_row(CHECK_MODEL, 5, 63, 5, 0, 8'h01, 8'h02, 8'h04, 0, 0, 0);
        add_row(CHECK_MODEL, 63, 7, 0, 7, 8'h08, 8'h10, 8'h20, 0, 0, 0);
        add_row(CHECK_MODEL, -5, 0, 5, 0, 8'h40, 8'h80, 8'hff, 0, 0, 0);
        // x-major and y-major with rising and falling slopes, the 45 degree case, ties
        add_row(CHECK_MODEL, 0, 0, 63, 20, 8'hf0, 8'h0f, 8'h3c, 0, 0, 0);
        add_row(CHECK_MODEL, 0, 63, 63, 40, 8'h5a, 8'ha5, 8'hc3, 0, 0, 0);
        add_row(CHECK_MODEL, 60, 10, 3, 30, 8'h7e, 8'he7, 8'h81, 0, 0, 0);
        add_row(CHECK_MODEL, 2, 0, 20, 63, 8'h9c, 8'h63, 8'h36, 0, 0, 0);
        add_row(CHECK_MODEL, 10, 60, 30, 2, 8'hde, 8'had, 8'hbe, 0, 0, 0);
        add_row(CHECK_MODEL, 40, 0, 10, 63, 8'hca, 8'hfe, 8'h01, 0, 0, 0);
        add_row(CHECK_MODEL, 0, 63, 63, 0, 8'hee, 8'h11, 8'h77, 0, 0, 0);
        add_row(CHECK_MODEL, 0, 0, 2, 1, 8'h31, 8'h41, 8'h59, 0, 0, 0);
        add_row(CHECK_MODEL, 0, 0, 1, 2, 8'h26, 8'h53, 8'h58, 0, 0, 0);
        add_row(CHECK_MODEL, -20, -10, 80, 70, 8'h97, 8'h93, 8'h23, 0, 0, 0);
        // Coordinate extremes: full-range lines crossing the screen
        add_row(CHECK_MODEL, -32768, 10, 32767, 10, 8'hff, 8'h00, 8'hff, 0, 0, 0);
        add_row(CHECK_MODEL, 20, 32767, 20, -32768, 8'h00, 8'hff, 8'h00, 0, 0, 0);
        add_row(CHECK_MODEL, -32768, -32768, 32767, 32767, 8'h84, 8'h62, 8'h64, 0, 0, 0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, sender idling lightly
        send_idle_pct = 26;
        foreach (directed_rows[i]) begin
            send_line(directed_rows[i].cmd, directed_rows[i].kind == CHECK_MODEL);
            if (directed_rows[i].kind == CHECK_ONE)
                pending_pixels.push_back(directed_rows[i].typed);
        end

        // Random lines under three sender pacings
        run_random(26, RANDOM_PER_PHASE);
        run_random(88, RANDOM_PER_PHASE);
        run_random(0, RANDOM_PER_PHASE);
        start <= 1'b0;

        // Drain: wait for every expected write, then let the walker finish
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drew %0d line requests (%0d directed, the rest random under three pacings)",
                 lines_sent, directed_rows.size());
        $display("Checked %0d pixel writes in %0d cycles, %0d mismatches",
                 pixels_checked, cycle_count, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
